### design/dps_pkg.sv
// Shared types, constants and the status code decoder for the dispenser poll sequencer.
package dps_pkg;

    // Request kinds, also used as poll step codes
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_VOLUME = 2'd1;
    localparam logic [1:0] KIND_MONEY  = 2'd2;

    // Pump states
    localparam logic [2:0] MODE_UNKNOWN   = 3'd0;
    localparam logic [2:0] MODE_IDLE      = 3'd1;
    localparam logic [2:0] MODE_PAUSED    = 3'd2;
    localparam logic [2:0] MODE_WAIT      = 3'd3;
    localparam logic [2:0] MODE_RUNNING   = 3'd4;
    localparam logic [2:0] MODE_FINISHING = 3'd5;
    localparam logic [2:0] MODE_DONE      = 3'd6;
    localparam logic [2:0] MODE_ERROR     = 3'd7;

    // Response command bytes: 'S', 'L', 'R'
    localparam logic [7:0] CMD_STATUS = 8'h53;
    localparam logic [7:0] CMD_VOLUME = 8'h4C;
    localparam logic [7:0] CMD_MONEY  = 8'h52;

    // Pump status codes reported by the dispenser
    localparam logic [15:0] CODE_IDLE      = 16'd10;
    localparam logic [15:0] CODE_PAUSED    = 16'd31;
    localparam logic [15:0] CODE_WAIT      = 16'd41;
    localparam logic [15:0] CODE_RUNNING   = 16'd61;
    localparam logic [15:0] CODE_FINISHING = 16'd81;
    localparam logic [15:0] CODE_DONE      = 16'd90;

    // Configuration register indexes and the default period
    localparam int          CFG_INDEX_W        = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_PERIOD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_PERIOD  = 8'd1;
    localparam logic [15:0] DEFAULT_PERIOD_MS  = 16'd200;

    // One service tick
    typedef struct packed {
        logic [31:0] now_ms;
        logic        link_busy;
        logic        resp_ready;
        logic        resp_fetched;
        logic [7:0]  resp_cmd;
        logic        resp_parse_ok;
        logic [15:0] resp_status_code;
        logic [7:0]  resp_status_char;
        logic [7:0]  resp_nozzle;
        logic [31:0] resp_amount;
    } tick_t;

    // Result of one tick
    typedef struct packed {
        logic        send_valid;
        logic [1:0]  send_kind;
        logic [2:0]  pump_state;
        logic [15:0] last_code;
        logic [7:0]  last_letter;
        logic [7:0]  last_nozzle_out;
        logic [31:0] volume_reading;
        logic        volume_valid;
        logic [31:0] money_amount;
        logic        money_valid;
    } result_t;

    // Configuration write
    typedef struct packed {
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [15:0]            wdata;
    } cfg_t;

    // Map a numeric status code to a pump state
    function automatic logic [2:0] mode_of_code(input logic [15:0] code);
        logic [2:0] mode;
        unique case (code)
            CODE_IDLE:      mode = MODE_IDLE;
            CODE_PAUSED:    mode = MODE_PAUSED;
            CODE_WAIT:      mode = MODE_WAIT;
            CODE_RUNNING:   mode = MODE_RUNNING;
            CODE_FINISHING: mode = MODE_FINISHING;
            CODE_DONE:      mode = MODE_DONE;
            default:        mode = MODE_UNKNOWN;
        endcase
        return mode;
    endfunction

endpackage

### design/dps_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface dps_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/dispenser_poll_sequencer.sv
// Dispenser poll sequencer: response handling, pump state and request scheduling.
//
// Usage:
//   tick   : sink channel, one transaction per service tick (time, link busy flag
//            and an already parsed response).
//   result : source channel, exactly one transaction per tick: the request to issue
//            (if any) and the pump state and readings after the tick.
//   cfg    : write channel for status_period_ms (index 0) and cycle_period_ms
//            (index 1); writing zero stores 200. Always ready. Write only while idle.
// Timing:
//   A tick lands in an input register, then the decode, state update and due-time
//   compare are combinational into the result register, which drives result. One tick
//   per cycle is sustained while result is taken; the limit is the combinational state
//   update loop (32-bit add and wrapping compare).
// Reset (rst_n low, asynchronous): poll step status, nothing awaited, next send time
//   0, pump state unknown, readings cleared, both periods 200.
// Stall: while result is not taken the result register holds; one more tick can
//   wait in the input register, after which tick.ready drops.
module dispenser_poll_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    dps_chan_if.sink    tick,
    dps_chan_if.source  result,
    dps_chan_if.sink    cfg
);
    import dps_pkg::*;

    // Pipeline registers
    logic        tick_valid_reg;
    tick_t       tick_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        advance;

    // Configuration
    logic [15:0] status_period_reg;
    logic [15:0] cycle_period_reg;
    logic [15:0] cfg_value;

    // Sequencer state
    logic [1:0]  poll_step_reg,   poll_step_next;
    logic        awaiting_reg,    awaiting_next;
    logic [31:0] next_send_reg,   next_send_next;
    logic [2:0]  pump_mode_reg,   pump_mode_next;
    logic [15:0] code_reg,        code_next;
    logic [7:0]  letter_reg,      letter_next;
    logic [7:0]  nozzle_reg,      nozzle_next;
    logic [31:0] volume_reg,      volume_next;
    logic [31:0] money_reg,       money_next;
    logic        volume_seen_reg, volume_seen_next;
    logic        money_seen_reg,  money_seen_next;

    logic        send;
    logic [31:0] due_diff;
    result_t     result_next;

    // Handshakes
    assign advance      = tick_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready   = !tick_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Configuration writes, zero stores the default
    assign cfg_value = (cfg.data.wdata == 16'd0) ? DEFAULT_PERIOD_MS : cfg.data.wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_period_reg <= DEFAULT_PERIOD_MS;
            cycle_period_reg  <= DEFAULT_PERIOD_MS;
        end
        else if (cfg.valid)
        begin
            if (cfg.data.reg_index == CFG_STATUS_PERIOD)
            begin
                status_period_reg <= cfg_value;
            end
            if (cfg.data.reg_index == CFG_CYCLE_PERIOD)
            begin
                cycle_period_reg <= cfg_value;
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            tick_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            tick_reg <= tick.data;
        end
    end

    // Response handling, step advance and due check for the registered tick
    always_comb
    begin
        poll_step_next   = poll_step_reg;
        awaiting_next    = awaiting_reg;
        next_send_next   = next_send_reg;
        pump_mode_next   = pump_mode_reg;
        code_next        = code_reg;
        letter_next      = letter_reg;
        nozzle_next      = nozzle_reg;
        volume_next      = volume_reg;
        money_next       = money_reg;
        volume_seen_next = volume_seen_reg;
        money_seen_next  = money_seen_reg;

        if (awaiting_reg && tick_reg.resp_ready)
        begin
            // take the fetched response
            if (tick_reg.resp_fetched)
            begin
                if (tick_reg.resp_cmd == CMD_STATUS)
                begin
                    if (tick_reg.resp_parse_ok)
                    begin
                        code_next      = tick_reg.resp_status_code;
                        letter_next    = tick_reg.resp_status_char;
                        pump_mode_next = mode_of_code(tick_reg.resp_status_code);
                    end
                    else
                    begin
                        pump_mode_next = MODE_ERROR;
                    end
                end
                else if (tick_reg.resp_cmd == CMD_VOLUME)
                begin
                    if (tick_reg.resp_parse_ok)
                    begin
                        nozzle_next      = tick_reg.resp_nozzle;
                        volume_next      = tick_reg.resp_amount;
                        volume_seen_next = 1'b1;
                    end
                end
                else if (tick_reg.resp_cmd == CMD_MONEY)
                begin
                    if (tick_reg.resp_parse_ok)
                    begin
                        nozzle_next     = tick_reg.resp_nozzle;
                        money_next      = tick_reg.resp_amount;
                        money_seen_next = 1'b1;
                    end
                end
            end

            // pick the next step and its due time
            awaiting_next = 1'b0;
            priority if (poll_step_reg == KIND_STATUS)
            begin
                if (pump_mode_next == MODE_RUNNING)
                begin
                    poll_step_next = KIND_VOLUME;
                    next_send_next = tick_reg.now_ms;
                end
                else
                begin
                    poll_step_next = KIND_STATUS;
                    next_send_next = tick_reg.now_ms + {16'd0, status_period_reg};
                end
            end
            else if (poll_step_reg == KIND_VOLUME)
            begin
                poll_step_next = KIND_MONEY;
                next_send_next = tick_reg.now_ms;
            end
            else
            begin
                poll_step_next = KIND_STATUS;
                next_send_next = tick_reg.now_ms + {16'd0,
                    (pump_mode_next == MODE_RUNNING) ? cycle_period_reg : status_period_reg};
            end
        end

        // wrapping due test
        due_diff = tick_reg.now_ms - next_send_next;
        send     = !awaiting_next && !due_diff[31] && !tick_reg.link_busy;
        if (send)
        begin
            awaiting_next = 1'b1;
        end

        result_next.send_valid      = send;
        result_next.send_kind       = send ? poll_step_next : KIND_STATUS;
        result_next.pump_state      = pump_mode_next;
        result_next.last_code       = code_next;
        result_next.last_letter     = letter_next;
        result_next.last_nozzle_out = nozzle_next;
        result_next.volume_reading  = volume_next;
        result_next.volume_valid    = volume_seen_next;
        result_next.money_amount    = money_next;
        result_next.money_valid     = money_seen_next;
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            poll_step_reg   <= KIND_STATUS;
            awaiting_reg    <= 1'b0;
            next_send_reg   <= 32'd0;
            pump_mode_reg   <= MODE_UNKNOWN;
            code_reg        <= 16'd0;
            letter_reg      <= 8'd0;
            nozzle_reg      <= 8'd0;
            volume_reg      <= 32'd0;
            money_reg       <= 32'd0;
            volume_seen_reg <= 1'b0;
            money_seen_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                poll_step_reg   <= poll_step_next;
                awaiting_reg    <= awaiting_next;
                next_send_reg   <= next_send_next;
                pump_mode_reg   <= pump_mode_next;
                code_reg        <= code_next;
                letter_reg      <= letter_next;
                nozzle_reg      <= nozzle_next;
                volume_reg      <= volume_next;
                money_reg       <= money_next;
                volume_seen_reg <= volume_seen_next;
                money_seen_reg  <= money_seen_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    // a request always leaves the sequencer waiting for its response
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && send) |=> awaiting_reg)
        else $error("request issued but no response awaited");

    // no request kind is reported without a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.send_valid) |-> (out_reg.send_kind == KIND_STATUS))
        else $error("request kind set without a request");

    // the poll step is always a real request kind
    assert property (@(posedge clk) disable iff (!rst_n)
        (poll_step_reg == KIND_STATUS) || (poll_step_reg == KIND_VOLUME) ||
        (poll_step_reg == KIND_MONEY))
        else $error("poll step out of range");

    // periods never hold zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (status_period_reg != 16'd0) && (cycle_period_reg != 16'd0))
        else $error("zero period stored");

    // a result register that is not taken keeps its state
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(pump_mode_reg)))
        else $error("state changed while result stalled");
`endif

endmodule

### tb/dispenser_poll_sequencer_test.sv
// Testbench for the dispenser poll sequencer: directed and random ticks against a predictor.
`timescale 1ns / 1ps

module dispenser_poll_sequencer_test;
    import dps_pkg::*;

    // Test values outside the listed codes and commands
    localparam logic [15:0] CODE_UNLISTED = 16'hFFFF;
    localparam logic [7:0]  CMD_OTHER     = 8'h00;

    logic clk = 1'b0;
    logic rst_n;

    dps_chan_if #(.payload_t(tick_t))   tick_ch ();
    dps_chan_if #(.payload_t(result_t)) result_ch ();
    dps_chan_if #(.payload_t(cfg_t))    cfg_ch ();

    dispenser_poll_sequencer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    always #10 clk = ~clk;

    // Predicted sequencer state, reset values
    logic [15:0] status_gap_ms = DEFAULT_PERIOD_MS;
    logic [15:0] cycle_gap_ms  = DEFAULT_PERIOD_MS;
    logic [1:0]  step_q        = KIND_STATUS;
    logic        resp_pending  = 1'b0;
    logic [31:0] due_ms        = '0;
    logic [2:0]  mode_q        = MODE_UNKNOWN;
    logic [15:0] code_q        = '0;
    logic [7:0]  letter_q      = '0;
    logic [7:0]  nozzle_q      = '0;
    logic [31:0] volume_q      = '0;
    logic [31:0] money_q       = '0;
    logic        volume_seen_q = 1'b0;
    logic        money_seen_q  = 1'b0;

    result_t     predicted_results[$];
    int          error_count  = 0;
    int          result_index = 0;
    logic [31:0] clock_ms     = '0;
    bit          allow_idle   = 1'b1;
    int          sink_hold    = 0;

    task automatic report_failure(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_failure($sformatf("result %0d %s: got %0h, expected %0h",
                                     result_index, name, got, want));
    endtask

    function automatic logic [2:0] pump_mode_for(input logic [15:0] code);
        case (code)
            CODE_IDLE:      return MODE_IDLE;
            CODE_PAUSED:    return MODE_PAUSED;
            CODE_WAIT:      return MODE_WAIT;
            CODE_RUNNING:   return MODE_RUNNING;
            CODE_FINISHING: return MODE_FINISHING;
            CODE_DONE:      return MODE_DONE;
            default:        return MODE_UNKNOWN;
        endcase
    endfunction

    // Command byte of the response that answers the outstanding request
    function automatic logic [7:0] awaited_cmd();
        if (step_q == KIND_STATUS)
            return CMD_STATUS;
        else if (step_q == KIND_VOLUME)
            return CMD_VOLUME;
        return CMD_MONEY;
    endfunction

    // One service tick of the predictor
    task automatic predict_tick(input tick_t t, output result_t r);
        logic        sent;
        logic [1:0]  kind;
        logic [31:0] lag;
        sent = 1'b0;
        kind = KIND_STATUS;
        // response handling, only while one is awaited
        if (resp_pending && t.resp_ready) begin
            if (t.resp_fetched) begin
                if (t.resp_cmd == CMD_STATUS) begin
                    if (t.resp_parse_ok) begin
                        code_q   = t.resp_status_code;
                        letter_q = t.resp_status_char;
                        mode_q   = pump_mode_for(t.resp_status_code);
                    end
                    else
                        mode_q = MODE_ERROR;
                end
                else if (t.resp_cmd == CMD_VOLUME && t.resp_parse_ok) begin
                    nozzle_q      = t.resp_nozzle;
                    volume_q      = t.resp_amount;
                    volume_seen_q = 1'b1;
                end
                else if (t.resp_cmd == CMD_MONEY && t.resp_parse_ok) begin
                    nozzle_q     = t.resp_nozzle;
                    money_q      = t.resp_amount;
                    money_seen_q = 1'b1;
                end
            end
            resp_pending = 1'b0;
            // choose the next request and when it is due
            if (step_q == KIND_STATUS) begin
                if (mode_q == MODE_RUNNING) begin
                    step_q = KIND_VOLUME;
                    due_ms = t.now_ms;
                end
                else begin
                    step_q = KIND_STATUS;
                    due_ms = t.now_ms + {16'd0, status_gap_ms};
                end
            end
            else if (step_q == KIND_VOLUME) begin
                step_q = KIND_MONEY;
                due_ms = t.now_ms;
            end
            else begin
                step_q = KIND_STATUS;
                due_ms = t.now_ms + {16'd0, (mode_q == MODE_RUNNING) ? cycle_gap_ms
                                                                    : status_gap_ms};
            end
        end
        // due test by wrapping signed difference
        if (!resp_pending) begin
            lag = t.now_ms - due_ms;
            if (!lag[31] && !t.link_busy) begin
                sent = 1'b1;
                if (step_q == KIND_STATUS)
                    kind = KIND_STATUS;
                else if (step_q == KIND_VOLUME)
                    kind = KIND_VOLUME;
                else
                    kind = KIND_MONEY;
                resp_pending = 1'b1;
            end
        end
        r.send_valid      = sent;
        r.send_kind       = kind;
        r.pump_state      = mode_q;
        r.last_code       = code_q;
        r.last_letter     = letter_q;
        r.last_nozzle_out = nozzle_q;
        r.volume_reading  = volume_q;
        r.volume_valid    = volume_seen_q;
        r.money_amount    = money_q;
        r.money_valid     = money_seen_q;
    endtask

    // Monitor: predicts on each accepted tick, checks each accepted result
    always @(posedge clk) begin : monitor
        result_t want;
        result_t got;
        logic [15:0] wval;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                wval = (cfg_ch.data.wdata == 16'd0) ? DEFAULT_PERIOD_MS : cfg_ch.data.wdata;
                if (cfg_ch.data.reg_index == CFG_STATUS_PERIOD)
                    status_gap_ms = wval;
                else if (cfg_ch.data.reg_index == CFG_CYCLE_PERIOD)
                    cycle_gap_ms = wval;
            end
            if (tick_ch.valid && tick_ch.ready) begin
                predict_tick(tick_ch.data, want);
                predicted_results.push_back(want);
            end
            if (result_ch.valid && result_ch.ready) begin
                got = result_ch.data;
                if (predicted_results.size() == 0)
                    report_failure($sformatf("result %0d arrived with no tick pending",
                                             result_index));
                else begin
                    want = predicted_results.pop_front();
                    check_field("send_valid", 32'(got.send_valid), 32'(want.send_valid));
                    check_field("send_kind", 32'(got.send_kind), 32'(want.send_kind));
                    check_field("pump_state", 32'(got.pump_state), 32'(want.pump_state));
                    check_field("last_code", 32'(got.last_code), 32'(want.last_code));
                    check_field("last_letter", 32'(got.last_letter), 32'(want.last_letter));
                    check_field("last_nozzle_out", 32'(got.last_nozzle_out),
                                32'(want.last_nozzle_out));
                    check_field("volume_reading", got.volume_reading, want.volume_reading);
                    check_field("volume_valid", 32'(got.volume_valid),
                                32'(want.volume_valid));
                    check_field("money_amount", got.money_amount, want.money_amount);
                    check_field("money_valid", 32'(got.money_valid), 32'(want.money_valid));
                end
                result_index++;
            end
        end
    end

    // Result side back-pressure in short random bursts
    always @(negedge clk) begin
        if (!allow_idle)
            result_ch.ready <= 1'b1;
        else if (sink_hold > 0) begin
            result_ch.ready <= 1'b0;
            sink_hold--;
        end
        else if ($urandom_range(0, 4) == 0) begin
            result_ch.ready <= 1'b0;
            sink_hold = $urandom_range(0, 3);
        end
        else
            result_ch.ready <= 1'b1;
    end

    // Drive one tick (caller is at a falling edge) and wait for its transaction
    task automatic send_tick(input tick_t t);
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        do begin
            @(posedge clk);
        end while (tick_ch.ready !== 1'b1);
    endtask

    task automatic directed_tick(input logic [31:0] dt, input logic busy, input logic ready,
                                 input logic fetched, input logic [7:0] cmd, input logic ok,
                                 input logic [15:0] code, input logic [31:0] amount);
        tick_t t;
        @(negedge clk);
        t = tick_t'({$urandom, $urandom, $urandom, $urandom});
        clock_ms           = clock_ms + dt;
        t.now_ms           = clock_ms;
        t.link_busy        = busy;
        t.resp_ready       = ready;
        t.resp_fetched     = fetched;
        t.resp_cmd         = cmd;
        t.resp_parse_ok    = ok;
        t.resp_status_code = code;
        t.resp_amount      = amount;
        send_tick(t);
    endtask

    // Mostly well formed: answers the outstanding request with random content
    task automatic random_ticks(input int count);
        tick_t t;
        int    pick;
        for (int i = 0; i < count; i++) begin
            if (allow_idle && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    @(negedge clk);
                    tick_ch.valid <= 1'b0;
                end
            end
            @(negedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                clock_ms = clock_ms + $urandom_range(0, 20);
            else if (pick < 88)
                clock_ms = clock_ms + $urandom_range(0, 400);
            else if (pick < 99)
                clock_ms = clock_ms + $urandom_range(0, 70000);
            else
                clock_ms = clock_ms + $urandom;
            t = tick_t'({$urandom, $urandom, $urandom, $urandom});
            t.now_ms    = clock_ms;
            t.link_busy = ($urandom_range(0, 7) == 0);
            if (resp_pending && $urandom_range(0, 3) != 0) begin
                t.resp_ready    = 1'b1;
                t.resp_fetched  = ($urandom_range(0, 15) != 0);
                t.resp_parse_ok = ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 15) != 0)
                    t.resp_cmd = awaited_cmd();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: t.resp_status_code = CODE_RUNNING;
                    4:          t.resp_status_code = CODE_IDLE;
                    5:          t.resp_status_code = CODE_PAUSED;
                    6:          t.resp_status_code = CODE_WAIT;
                    7:          t.resp_status_code = CODE_FINISHING;
                    8:          t.resp_status_code = CODE_DONE;
                    default:    ;
                endcase
                case ($urandom_range(0, 9))
                    0:       t.resp_amount = '0;
                    1:       t.resp_amount = '1;
                    default: ;
                endcase
            end
            else
                t.resp_ready = ($urandom_range(0, 9) == 0);
            send_tick(t);
        end
    endtask

    // Let every tick in flight come out before touching the registers
    task automatic settle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_period(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{reg_index: idx, wdata: val};
        do begin
            @(posedge clk);
        end while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hand written sequence through the polling cycle and the corner cases
    task automatic test_directed_sequence();
        logic [15:0] codes [6];
        codes = '{CODE_IDLE, CODE_PAUSED, CODE_WAIT, CODE_FINISHING, CODE_DONE, CODE_UNLISTED};
        // first poll at reset time, then a full running cycle with extreme amounts
        directed_tick(0, 1'b0, 1'b0, 1'b0, CMD_STATUS, 1'b0, 16'd0, 32'd0);
        directed_tick(3, 1'b0, 1'b1, 1'b1, CMD_STATUS, 1'b1, CODE_RUNNING, 32'd0);
        directed_tick(1, 1'b0, 1'b1, 1'b1, CMD_VOLUME, 1'b1, 16'd0, 32'hFFFF_FFFF);
        directed_tick(1, 1'b0, 1'b1, 1'b1, CMD_MONEY, 1'b1, 16'd0, 32'd0);
        // response while nothing is awaited, then busy link exactly when due
        directed_tick(50, 1'b0, 1'b1, 1'b1, CMD_STATUS, 1'b1, CODE_DONE, 32'd0);
        directed_tick(150, 1'b1, 1'b0, 1'b0, CMD_STATUS, 1'b0, 16'd0, 32'd0);
        directed_tick(0, 1'b0, 1'b0, 1'b0, CMD_STATUS, 1'b0, 16'd0, 32'd0);
        // running again: volume parse failure, money not fetched
        directed_tick(2, 1'b0, 1'b1, 1'b1, CMD_STATUS, 1'b1, CODE_RUNNING, 32'd0);
        directed_tick(1, 1'b0, 1'b1, 1'b1, CMD_VOLUME, 1'b0, 16'd0, 32'h1234_5678);
        directed_tick(1, 1'b0, 1'b1, 1'b0, CMD_MONEY, 1'b1, 16'd0, 32'hDEAD_BEEF);
        // unknown command byte, status parse failure in the middle of a cycle
        directed_tick(200, 1'b0, 1'b0, 1'b0, CMD_STATUS, 1'b0, 16'd0, 32'd0);
        directed_tick(1, 1'b0, 1'b1, 1'b1, CMD_OTHER, 1'b1, 16'd0, 32'd0);
        directed_tick(1, 1'b0, 1'b1, 1'b1, CMD_STATUS, 1'b0, 16'd0, 32'd0);
        directed_tick(1, 1'b0, 1'b1, 1'b1, CMD_MONEY, 1'b1, 16'd0, 32'd1);
        // every other status code, plus one that is not listed
        foreach (codes[i]) begin
            directed_tick(200, 1'b0, 1'b0, 1'b0, CMD_STATUS, 1'b0, 16'd0, 32'd0);
            directed_tick(1, 1'b0, 1'b1, 1'b1, CMD_STATUS, 1'b1, codes[i], 32'd0);
        end
    endtask

    // Both periods through their extremes, zero and an unmapped index
    task automatic test_period_registers();
        settle();
        write_period(CFG_STATUS_PERIOD, 16'd1);
        write_period(CFG_CYCLE_PERIOD, 16'hFFFF);
        random_ticks(110);
        settle();
        write_period(CFG_STATUS_PERIOD, 16'hFFFF);
        write_period(CFG_CYCLE_PERIOD, 16'd1);
        random_ticks(110);
        settle();
        write_period(CFG_STATUS_PERIOD, 16'd0);
        write_period(CFG_CYCLE_PERIOD, 16'd0);
        write_period(CFG_INDEX_W'($urandom_range(2, 255)), 16'($urandom));
        random_ticks(110);
        settle();
        write_period(CFG_STATUS_PERIOD, 16'($urandom_range(1, 1000)));
        write_period(CFG_CYCLE_PERIOD, 16'($urandom_range(1, 1000)));
        random_ticks(100);
    endtask

    // Millisecond counter crossing its wrap point
    task automatic test_time_wrap();
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        random_ticks(40);
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate();
        allow_idle = 1'b0;
        random_ticks(80);
    endtask

    initial begin
        rst_n           = 1'b0;
        tick_ch.valid   = 1'b0;
        tick_ch.data    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        result_ch.ready = 1'b1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_sequence();
        test_period_registers();
        test_time_wrap();
        test_full_rate();

        // drain and watch for stray results
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
